@@ hdl/pge_pkg.sv @@
// Shared types and constants for the permutation gather engine.
// Used by pge_ctrl, pge_datapath and the top level; depends on nothing.
`default_nettype none

package pge_pkg;

    localparam int MODE_W = 2;
    localparam int PIDX_W = 7;
    localparam int POS_W  = 6;
    localparam int ELEM_W = 6;

    localparam int ARRAY_SIZE_DEF = 64;
    localparam int MAX_PERMS_DEF  = 128;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_IDENT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_APPLY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_READ
    } t_state;

    typedef struct packed {
        logic load_wr;
        logic ident;
        logic apply_start;
        logic flip;
        logic read_issue;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic pidx_ok;
        logic pos_ok;
        logic apply_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

@@ hdl/pge_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; the read data holds while no read is issued.
`default_nettype none

module pge_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/pge_ctrl.sv @@
// Controller state machine of the permutation gather engine.
// Depends on pge_pkg; drives the datapath through t_cmd and watches t_status.
`default_nettype none

module pge_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [pge_pkg::MODE_W-1:0]  i_mode,
    input  wire pge_pkg::t_status            i_status,
    output logic                             o_ready,
    output pge_pkg::t_cmd                    o_cmd
);

    pge_pkg::t_state r_state;
    pge_pkg::t_state n_state;
    logic            w_accept;

    assign o_ready  = (r_state == pge_pkg::ST_IDLE);
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pge_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pge_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_mode == pge_pkg::MODE_APPLY && i_status.pidx_ok) begin
                        n_state = pge_pkg::ST_APPLY;
                    end else if (i_mode == pge_pkg::MODE_READ) begin
                        n_state = pge_pkg::ST_READ;
                    end
                end
            end
            pge_pkg::ST_APPLY: begin
                if (i_status.apply_done) begin
                    n_state = pge_pkg::ST_IDLE;
                end
            end
            pge_pkg::ST_READ: begin
                if (i_status.out_free) begin
                    n_state = pge_pkg::ST_IDLE;
                end
            end
            default: n_state = pge_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            pge_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_mode)
                        pge_pkg::MODE_LOAD: begin
                            o_cmd.load_wr = i_status.pidx_ok && i_status.pos_ok;
                        end
                        pge_pkg::MODE_IDENT: begin
                            o_cmd.ident = 1'b1;
                        end
                        pge_pkg::MODE_APPLY: begin
                            o_cmd.apply_start = i_status.pidx_ok;
                        end
                        pge_pkg::MODE_READ: begin
                            o_cmd.read_issue = 1'b1;
                        end
                        default: o_cmd = '0;
                    endcase
                end
            end
            pge_pkg::ST_APPLY: begin
                o_cmd.flip = i_status.apply_done;
            end
            pge_pkg::ST_READ: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/pge_datapath.sv @@
// Datapath of the permutation gather engine: permutation table, element banks,
// gather pipeline and output register. Depends on pge_pkg and pge_ram.
`default_nettype none

module pge_datapath #(
    parameter int ARRAY_SIZE = pge_pkg::ARRAY_SIZE_DEF,
    parameter int MAX_PERMS  = pge_pkg::MAX_PERMS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire pge_pkg::t_cmd               i_cmd,
    input  wire logic [pge_pkg::PIDX_W-1:0]  i_perm_index,
    input  wire logic [pge_pkg::POS_W-1:0]   i_position,
    input  wire logic [pge_pkg::ELEM_W-1:0]  i_value,
    input  wire logic                        i_ready,
    output pge_pkg::t_status                 o_status,
    output logic                             o_valid,
    output logic [pge_pkg::ELEM_W-1:0]       o_element
);

    localparam int AW     = $clog2(ARRAY_SIZE);
    localparam int PW     = (MAX_PERMS > 1) ? $clog2(MAX_PERMS) : 1;
    localparam int TDEPTH = 2 ** (PW + AW);
    localparam int BDEPTH = 2 ** (AW + 1);
    localparam int SLOTS  = 2 ** AW;

    logic                        r_bank;
    logic [BDEPTH-1:0]           r_bvld;
    logic [PW-1:0]               r_pidx;
    logic [AW:0]                 r_k;
    logic                        r_s1_vld;
    logic [AW-1:0]               r_s1_k;
    logic                        r_s2_vld;
    logic [AW-1:0]               r_s2_k;
    logic                        r_rbvld;
    logic [AW-1:0]               r_rsrc;
    logic                        r_rd_ok;
    logic                        r_out_vld;
    logic [pge_pkg::ELEM_W-1:0]  r_out_elem;

    logic                        w_issue;
    logic [pge_pkg::ELEM_W-1:0]  w_tdata;
    logic [AW-1:0]               w_src;
    logic                        w_bre;
    logic [AW:0]                 w_braddr;
    logic [pge_pkg::ELEM_W-1:0]  w_bdata;
    logic [pge_pkg::ELEM_W-1:0]  w_gather;

    assign o_status.pidx_ok    = ({1'b0, i_perm_index} < (pge_pkg::PIDX_W + 1)'(MAX_PERMS));
    assign o_status.pos_ok     = ({1'b0, i_position} < (pge_pkg::POS_W + 1)'(ARRAY_SIZE));
    assign o_status.apply_done = (r_k == (AW + 1)'(ARRAY_SIZE)) && !r_s1_vld && !r_s2_vld;
    assign o_status.out_free   = !r_out_vld || i_ready;

    assign w_issue = (r_k < (AW + 1)'(ARRAY_SIZE));

    pge_ram #(
        .WIDTH (pge_pkg::ELEM_W),
        .DEPTH (TDEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr),
        .i_waddr ({i_perm_index[PW-1:0], i_position[AW-1:0]}),
        .i_wdata (i_value),
        .i_re    (w_issue),
        .i_raddr ({r_pidx, r_k[AW-1:0]}),
        .o_rdata (w_tdata)
    );

    assign w_src = ({1'b0, w_tdata} >= (pge_pkg::ELEM_W + 1)'(ARRAY_SIZE))
                 ? AW'(ARRAY_SIZE - 1) : w_tdata[AW-1:0];

    assign w_bre    = i_cmd.read_issue || r_s1_vld;
    assign w_braddr = i_cmd.read_issue ? {r_bank, i_position[AW-1:0]} : {r_bank, w_src};
    assign w_gather = r_rbvld ? w_bdata : (pge_pkg::ELEM_W)'(r_rsrc);

    pge_ram #(
        .WIDTH (pge_pkg::ELEM_W),
        .DEPTH (BDEPTH)
    ) u_banks (
        .i_clk   (i_clk),
        .i_we    (r_s2_vld),
        .i_waddr ({~r_bank, r_s2_k}),
        .i_wdata (w_gather),
        .i_re    (w_bre),
        .i_raddr (w_braddr),
        .o_rdata (w_bdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank    <= 1'b0;
            r_bvld    <= '0;
            r_k       <= (AW + 1)'(ARRAY_SIZE);
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.flip) begin
                r_bank <= ~r_bank;
            end
            if (i_cmd.ident) begin
                for (int i = 0; i < SLOTS; i++) begin
                    r_bvld[{r_bank, AW'(i)}] <= 1'b0;
                end
            end
            if (r_s2_vld) begin
                r_bvld[{~r_bank, r_s2_k}] <= 1'b1;
            end
            if (i_cmd.apply_start) begin
                r_k <= '0;
            end else if (w_issue) begin
                r_k <= r_k + 1'b1;
            end
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply_start) begin
            r_pidx <= i_perm_index[PW-1:0];
        end
        r_s1_k <= r_k[AW-1:0];
        r_s2_k <= r_s1_k;
        if (w_bre) begin
            r_rbvld <= r_bvld[w_braddr];
            r_rsrc  <= w_braddr[AW-1:0];
        end
        if (i_cmd.read_issue) begin
            r_rd_ok <= o_status.pos_ok;
        end
        if (i_cmd.out_load) begin
            r_out_elem <= r_rd_ok ? w_gather : '0;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_element = r_out_elem;

endmodule

`default_nettype wire

@@ hdl/permutation_gather_engine_unit.sv @@
// Top level of the permutation gather engine.
// Depends on pge_pkg, pge_ctrl, pge_datapath and pge_ram.
//
//   Channel | Direction | Handshake          | Word
//   --------+-----------+--------------------+------------------------------------------
//   input   | in        | i_valid / o_ready  | i_mode, i_perm_index, i_position, i_value
//   result  | out       | o_valid / i_ready  | o_element (read words only)
//
// A load or identity word is taken while the controller stays idle, and a read word waits
// in the read state until the output register is free. An apply word runs the gather
// pipeline, reading the table RAM and the bank RAM once per position, until it drains.
// Reset clears the state machine, the bank valid bits and the bank select at once;
// no clearing pass runs. o_ready is high only while the controller is idle, and a
// result waiting in the output register stalls only a following read word.
`default_nettype none

module permutation_gather_engine_unit #(
    parameter int ARRAY_SIZE = pge_pkg::ARRAY_SIZE_DEF,
    parameter int MAX_PERMS  = pge_pkg::MAX_PERMS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [pge_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [pge_pkg::PIDX_W-1:0]  i_perm_index,
    input  wire logic [pge_pkg::POS_W-1:0]   i_position,
    input  wire logic [pge_pkg::ELEM_W-1:0]  i_value,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [pge_pkg::ELEM_W-1:0]       o_element
);

    pge_pkg::t_cmd    w_cmd;
    pge_pkg::t_status w_status;

    pge_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .i_status (w_status),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd)
    );

    pge_datapath #(
        .ARRAY_SIZE (ARRAY_SIZE),
        .MAX_PERMS  (MAX_PERMS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_perm_index (i_perm_index),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_ready      (i_ready),
        .o_status     (w_status),
        .o_valid      (o_valid),
        .o_element    (o_element)
    );

endmodule

`default_nettype wire
